// ===== rtl/core/ctq_pkg.sv =====
package ctq_pkg;

  localparam int unsigned CTQ_DEPTH = 8;
  localparam int unsigned OCC_W     = 4;

  // command kinds
  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_POWER = 2'd1;
  localparam logic [1:0] KIND_SYNC  = 2'd2;
  localparam logic [1:0] KIND_POP   = 2'd3;

  // task types
  localparam logic [2:0] T_POWER_ON  = 3'd0;
  localparam logic [2:0] T_SHUTDOWN  = 3'd1;
  localparam logic [2:0] T_RENDER    = 3'd2;
  localparam logic [2:0] T_SYNC      = 3'd3;
  localparam logic [2:0] T_SAVE      = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] task_type;
    logic [7:0] layer;
  } ctq_in_t;

  typedef struct packed {
    logic             accepted;
    logic             overflow;
    logic             pop_valid;
    logic [2:0]       pop_type;
    logic [7:0]       pop_layer;
    logic [OCC_W-1:0] occupancy;
  } ctq_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctq_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctq_cmd_t;

  typedef struct packed {
    logic scan_done;
  } ctq_sts_t;

  // true when a push carries a type that is queued
  function automatic logic type_ok(input logic [1:0] kind, input logic [2:0] t);
    return (kind == KIND_SYNC) || (t <= T_SAVE);
  endfunction

  // decides whether a stored entry survives the compaction of this command
  function automatic logic keep_entry(input logic [1:0] kind, input logic [2:0] t,
                                      input logic [2:0] e, input logic first);
    logic k;
    k = 1'b1;
    if (kind == KIND_POP) begin
      k = !first;
    end else if (kind == KIND_SYNC) begin
      k = (e != T_SYNC);
    end else if (t > T_SAVE) begin
      k = 1'b1;
    end else if (kind == KIND_POWER && t == T_SHUTDOWN) begin
      k = (e == T_SAVE) || (e == T_SYNC);
    end else if (kind == KIND_POWER && t == T_POWER_ON) begin
      k = (e != T_POWER_ON) && (e != T_SHUTDOWN);
    end else begin
      k = (e != t);
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/ctq_ctrl.sv =====
module ctq_ctrl
  import ctq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ctq_sts_t sts,
  output ctq_cmd_t cmd,
  output logic     busy
);

  ctq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ctq_datapath.sv =====
module ctq_datapath
  import ctq_pkg::*;
#(
  parameter int unsigned DEPTH = CTQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  ctq_in_t  cmd_in,
  input  ctq_cmd_t cmd,
  output ctq_sts_t sts,
  output logic     done,
  output ctq_out_t result
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = 11;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;

  ctq_in_t       op;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] wr_idx;
  logic          rd_pending;
  logic          rd_first;
  logic          head_seen;
  logic [EW-1:0] head;

  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wdata;
  logic          keep;
  logic          is_push;
  logic          push_ok;
  logic          room;

  assign rd_en   = cmd.scan && (rd_idx < count);
  assign keep    = keep_entry(op.kind, op.task_type, rdata[EW-1:8], rd_first);
  assign is_push = (op.kind != KIND_POP);
  assign room    = (wr_idx < CW'(DEPTH));
  assign push_ok = is_push && type_ok(op.kind, op.task_type);

  assign sts.scan_done = (rd_idx >= count) && !rd_pending;

  // one write port: survivors during the scan, the new entry at the end
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx[AW-1:0];
    wdata   = rdata;
    if (cmd.scan && rd_pending && keep) begin
      wr_en = 1'b1;
    end else if (cmd.finish && push_ok && room) begin
      wr_en = 1'b1;
      if (op.kind == KIND_SYNC) begin
        wdata = {T_SYNC, op.layer};
      end else begin
        wdata = {op.task_type, 8'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_idx[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= cmd_in;
    end
    if (cmd.scan && rd_pending && rd_first) begin
      head <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      rd_idx     <= '0;
      wr_idx     <= '0;
      rd_pending <= 1'b0;
      rd_first   <= 1'b0;
      head_seen  <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        rd_idx     <= '0;
        wr_idx     <= '0;
        rd_pending <= 1'b0;
        head_seen  <= 1'b0;
      end
      if (cmd.scan) begin
        rd_pending <= rd_en;
        rd_first   <= (rd_idx == '0);
        if (rd_en) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (rd_pending && keep) begin
          wr_idx <= wr_idx + 1'b1;
        end
        if (rd_pending && rd_first) begin
          head_seen <= 1'b1;
        end
      end
      if (cmd.finish) begin
        done <= 1'b1;
        if (push_ok && room) begin
          count <= wr_idx + 1'b1;
        end else begin
          count <= wr_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.accepted  <= push_ok && room;
      result.overflow  <= push_ok && !room;
      result.pop_valid <= !is_push && head_seen;
      if (!is_push && head_seen) begin
        result.pop_type  <= head[EW-1:8];
        result.pop_layer <= (head[EW-1:8] == T_SYNC) ? head[7:0] : 8'd0;
      end else begin
        result.pop_type  <= '0;
        result.pop_layer <= '0;
      end
      if (push_ok && room) begin
        result.occupancy <= OCC_W'(wr_idx + 1'b1);
      end else begin
        result.occupancy <= OCC_W'(wr_idx);
      end
    end
  end

endmodule

// ===== rtl/core/coalescing_task_queue.sv =====
// a new command is taken only while the block is idle; the compaction walk goes through
//   the single read / single write port of the entry memory
// reset: synchronous active-high rst empties the queue and returns to idle; the entry
//   memory itself is not cleared, only the fill count
// the result is shown for one cycle with done and cannot be stalled by the receiver
module coalescing_task_queue
  import ctq_pkg::*;
#(
  parameter int unsigned DEPTH = CTQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ctq_in_t  cmd,
  output logic     busy,
  output logic     done,
  output ctq_out_t result
);

  // command and status between the sequencer and the queue datapath
  ctq_cmd_t ctl_cmd;
  ctq_sts_t ctl_sts;

  // sequencer: idle -> scan (walk and compact the stored entries) -> finish (append, report)
  ctq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (ctl_sts),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  // datapath: entry memory, read/write indexes, fill count and result register
  // a pop is handled as a compaction that drops the head entry
  ctq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd_in (cmd),
    .cmd    (ctl_cmd),
    .sts    (ctl_sts),
    .done   (done),
    .result (result)
  );

endmodule

// ===== rtl/core/ctq_checker.sv =====
module ctq_checker
  import ctq_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input ctq_out_t result
);

  // the sequencer is back to idle when the result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // a start transfer makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start transfer not taken");

  // a push is never reported as both appended and dropped
  a_acc_ovf: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.accepted && result.overflow))
    else $error("accepted and overflow together");

  // a pop result never reports push status
  a_pop_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.pop_valid) |-> (!result.accepted && !result.overflow))
    else $error("pop result carries push flags");

  // an appended entry leaves the queue non-empty
  a_acc_occ: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |-> (result.occupancy != '0))
    else $error("accepted with empty queue");

endmodule

bind coalescing_task_queue ctq_checker u_chk (.*);
